@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/itoa_fmt_pkg.sv @@
// Types, constants and helpers of the integer-to-ASCII formatter.
package itoa_fmt_pkg;

	localparam int MAX_WIDTH_DEF = 32;
	localparam int MAG_W         = 32;
	localparam int FW_W          = 6;
	localparam int DIGITS        = 10;
	localparam int DIG_IDX_W     = 4;

	localparam logic [1:0] KIND_DEC = 2'd0;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	typedef struct packed {
		logic [1:0]       kind;
		logic [MAG_W-1:0] value_bits;
		logic             flag_plus;
		logic             flag_space;
		logic             flag_left;
		logic             flag_hash;
		logic [FW_W-1:0]  field_width;
	} fmt_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} fmt_out_t;

	// One digit 0..15 to its ASCII character.
	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0, d};
		end
		return (up ? CH_A_UP : CH_A_LO) + {4'b0, d} - 8'd10;
	endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter_unit.sv @@
// Integer-to-ASCII formatter: %d / %x / %X text, one character per item.
//
//  channel | signals                         | payload
//  --------+---------------------------------+-----------------------------
//  in      | in_valid, in_stall (driven)     | in_item  : fmt_in_t
//  out     | out_valid (driven), out_stall   | out_item : fmt_out_t
//
// Decimal: accept, shift-add-3 steps in the BCD unit (ST_CONV), a sizing
// state (ST_SIZE), then one character per cycle while out_stall does not hold it.
// Hex skips the BCD unit. Text length is 1..max(MAX_WIDTH, 11).
// in_stall is high from the accept edge until the last character is loaded
// into the output register; out_stall only holds the character sequencer and the output register.
// Reset returns the sequencer to idle and empties the output register.
module integer_to_ascii_formatter_unit import itoa_fmt_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  fmt_in_t  in_item,
	output logic     out_valid,
	input  logic     out_stall,
	output fmt_out_t out_item
);

	// Position counters must hold MAX_WIDTH and the raw field width.
	localparam int CNT_W  = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
	localparam int STEP_W = $clog2(MAG_W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIZE = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [MAG_W-1:0]            mag_q;
	logic [DIGITS-1:0][3:0]      dig_q;
	logic [STEP_W-1:0]           step_q;
	logic                        hex_q, upper_q, neg_q, plus_q, space_q, left_q, hash_q;
	logic [CNT_W-1:0]            width_q;
	logic                        pfx_dec_q;
	logic [CNT_W-1:0]            b1_q, b2_q, b3_q, len_q, pos_q;
	logic                        out_valid_q;
	fmt_out_t                    out_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        emit;
	logic [CNT_W-1:0]            fw_ext;
	logic [MAG_W-1:0]            mag_in;
	logic [DIGITS*4-1:0]         dd_next;
	logic [DIG_IDX_W-1:0]        ndig;
	logic [1:0]                  plen;
	logic [CNT_W-1:0]            txt_len, pad, pre;
	logic [7:0]                  ch;
	logic [DIG_IDX_W-1:0]        dig_idx;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign fw_ext   = CNT_W'(in_item.field_width);
	assign mag_in   = in_item.value_bits[MAG_W-1] ? (~in_item.value_bits + 1'b1)
	                                              : in_item.value_bits;

	// BCD unit: add 3 to every digit of 5 or more, then shift one bit in.
	always_comb begin
		logic [DIGITS-1:0][3:0] adj;
		logic [DIGITS*4-1:0]    flat;
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		flat    = adj;
		dd_next = {flat[DIGITS*4-2:0], mag_q[MAG_W-1]};
	end

	// Digit count: highest nonzero digit, at least one.
	always_comb begin
		ndig = DIG_IDX_W'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (dig_q[i] != 4'd0) begin
				ndig = DIG_IDX_W'(i + 1);
			end
		end
	end

	// Sizing: prefix, padding and segment boundaries of the text.
	always_comb begin
		if (hex_q) begin
			plen = (hash_q && (dig_q != '0)) ? 2'd2 : 2'd0;
		end else begin
			plen = (neg_q || plus_q || space_q) ? 2'd1 : 2'd0;
		end
		txt_len = CNT_W'(plen) + CNT_W'(ndig);
		pad     = (!hex_q && (width_q > txt_len)) ? width_q - txt_len : '0;
		pre     = left_q ? '0 : pad;
	end

	// Character at the current position: pad, prefix, digits, pad.
	always_comb begin
		dig_idx = DIG_IDX_W'(b3_q - pos_q - 1'b1);
		if (pos_q < b1_q) begin
			ch = CH_SPACE;
		end else if (pos_q < b2_q) begin
			if (!pfx_dec_q) begin
				ch = (pos_q == b1_q) ? CH_ZERO : (upper_q ? CH_X_UP : CH_X_LO);
			end else if (neg_q) begin
				ch = CH_MINUS;
			end else if (plus_q) begin
				ch = CH_PLUS;
			end else begin
				ch = CH_SPACE;
			end
		end else if (pos_q < b3_q) begin
			ch = hex_char(dig_q[dig_idx], upper_q);
		end else begin
			ch = CH_SPACE;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q  <= '0;
						state_q <= (in_item.kind == KIND_DEC) ? ST_CONV : ST_SIZE;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MAG_W - 1)) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == len_q - 1'b1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item data path
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hex_q   <= (in_item.kind != KIND_DEC);
			upper_q <= in_item.kind[1];
			neg_q   <= (in_item.kind == KIND_DEC) && in_item.value_bits[MAG_W-1];
			plus_q  <= in_item.flag_plus;
			space_q <= in_item.flag_space;
			left_q  <= in_item.flag_left;
			hash_q  <= in_item.flag_hash;
			width_q <= (fw_ext > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : fw_ext;
			if (in_item.kind == KIND_DEC) begin
				mag_q <= mag_in;
				dig_q <= '0;
			end else begin
				mag_q <= in_item.value_bits;
				dig_q <= (DIGITS*4)'(in_item.value_bits);
			end
		end else if (state_q == ST_CONV) begin
			dig_q <= dd_next;
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
		if (state_q == ST_SIZE) begin
			pfx_dec_q <= !hex_q;
			b1_q      <= pre;
			b2_q      <= pre + CNT_W'(plen);
			b3_q      <= pre + txt_len;
			len_q     <= txt_len + pad;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_char <= ch;
			out_q.last     <= (pos_q == len_q - 1'b1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ rtl/core/itoa_fmt_chk.sv @@
// Port checker for the integer-to-ASCII formatter, bound to the formatter module.
`include "assert_macros.svh"

module itoa_fmt_chk import itoa_fmt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input fmt_out_t out_item
);

	// a held character stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))

	// one item at a time: busy right after an accept
	`ASSERT_NEXT(a_busy_after_acc, clk, arst_n, in_valid && !in_stall, in_stall)

	// while text is still coming, no new item is taken
	`ASSERT_IMPL(a_busy_mid_text, clk, arst_n, out_valid && !out_item.last, in_stall)

endmodule

bind integer_to_ascii_formatter_unit itoa_fmt_chk u_itoa_fmt_chk (.*);
